### rtl/camera_offset_to_world_unit_assert.svh
// Assertion macros for the camera offset to world unit.
// Included by the top level, which checks its own pipeline; no other dependency.
`ifndef CAMERA_OFFSET_TO_WORLD_UNIT_ASSERT_SVH
`define CAMERA_OFFSET_TO_WORLD_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define COWT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define COWT_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define COWT_ASSERT_IMP(label, ante, cons, msg)
`define COWT_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

### rtl/cowt_pkg.sv
// Shared constants and types of the camera offset to world unit.
// No dependencies; used by cowt_phase, cowt_sine_rom and the top level.
package cowt_pkg;

   localparam int ANGLE_W = 17;
   localparam int COORD_W = 32;
   localparam int QUAD_W = 2;

   // Angles are in 1/128 degree.
   localparam int FULL_TURN = 46080;
   localparam int QUARTER_TURN = 11520;

   // Half pi in Q30, used to build the quarter-wave sine table.
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // A quarter turn is 256 * 45; this is ceil(2^32 / 45) for the divide by 45.
   localparam logic [26:0] RECIP_45 = 27'd95443718;
   localparam int RECIP_SHIFT = 32;
   localparam int PRE_SHIFT = 8;

   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

   // Positions and offsets that ride alongside the angle pipeline.
   // The first member sits in the top bits, so the word order is reversed here.
   typedef struct packed {
      logic signed [COORD_W-1:0] off_u;
      logic signed [COORD_W-1:0] off_f;
      logic signed [COORD_W-1:0] off_r;
      logic signed [COORD_W-1:0] pos_z;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_x;
   } coord_set_type;

endpackage

### rtl/cowt_phase.sv
// Angle to table phase: wraps an angle into one turn, splits off the quadrant
// and scales the rest to a table index over four stages. Uses cowt_pkg.
module cowt_phase #(
   parameter int D = 1024
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [cowt_pkg::ANGLE_W-1:0] angle,
   output logic [cowt_pkg::QUAD_W-1:0]         quad,
   output logic [$clog2(D)-1:0]                index
);

   localparam int RW = $clog2(D);
   localparam int TW = 20;
   localparam int PW = 30;
   localparam int MW = TW + 27;
   localparam int PRE = cowt_pkg::PRE_SHIFT;
   localparam logic signed [18:0] FT = 19'(cowt_pkg::FULL_TURN);

   logic signed [18:0] ext;
   logic signed [18:0] red;
   logic [15:0] red_in, red_ff;
   logic [cowt_pkg::QUAD_W-1:0] q2_in, q2_ff, q3_ff, q4_ff;
   logic [13:0] vq_in, vq_ff;
   logic [PW-1:0] scaled;
   logic [TW-1:0] t_in, t_ff;
   logic [MW-1:0] recip_prod;
   logic [RW-1:0] idx_in, idx_ff;

   // Stage one wraps the angle into [0, one turn).
   always_comb begin
      ext = 19'(angle);
      if (ext < -FT) begin
         red = ext + FT + FT;
      end else if (ext < 19'sd0) begin
         red = ext + FT;
      end else if (ext >= FT) begin
         red = ext - FT;
      end else begin
         red = ext;
      end
      red_in = red[15:0];
   end

   // Stage two takes the quadrant off and keeps the angle within it.
   always_comb begin
      if (red_ff >= 16'(3 * cowt_pkg::QUARTER_TURN)) begin
         q2_in = 2'd3;
         vq_in = 14'(red_ff - 16'(3 * cowt_pkg::QUARTER_TURN));
      end else if (red_ff >= 16'(2 * cowt_pkg::QUARTER_TURN)) begin
         q2_in = 2'd2;
         vq_in = 14'(red_ff - 16'(2 * cowt_pkg::QUARTER_TURN));
      end else if (red_ff >= 16'(cowt_pkg::QUARTER_TURN)) begin
         q2_in = 2'd1;
         vq_in = 14'(red_ff - 16'(cowt_pkg::QUARTER_TURN));
      end else begin
         q2_in = 2'd0;
         vq_in = red_ff[13:0];
      end
   end

   // Stage three scales by the depth and drops the factor 256 of a quarter turn.
   always_comb begin
      scaled = PW'(vq_ff) * PW'(D);
      t_in = scaled[PRE + TW - 1:PRE];
   end

   // Stage four divides by 45 through the reciprocal, exact over this range.
   always_comb begin
      recip_prod = MW'(t_ff) * MW'(cowt_pkg::RECIP_45);
      idx_in = recip_prod[cowt_pkg::RECIP_SHIFT + RW - 1:cowt_pkg::RECIP_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         red_ff <= red_in;
         q2_ff <= q2_in;
         vq_ff <= vq_in;
         q3_ff <= q2_ff;
         t_ff <= t_in;
         q4_ff <= q3_ff;
         idx_ff <= idx_in;
      end
   end

   assign quad = q4_ff;
   assign index = idx_ff;

endmodule

### rtl/cowt_sine_rom.sv
// Quarter-wave sine table with two read ports, filled from a table built at
// elaboration by a sweep after reset. Uses cowt_pkg.
module cowt_sine_rom #(
   parameter int D = 1024,
   parameter int F = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic [$clog2(D+1)-1:0]   addr_a,
   input  logic [$clog2(D+1)-1:0]   addr_b,
   output logic [F:0]               data_a,
   output logic [F:0]               data_b,
   output logic                     fill_done
);

   localparam int AW = $clog2(D + 1);

   typedef logic [F:0] entry_type;
   typedef entry_type tab_type [0:D];

   // Taylor series of sine through x^17 in Q30, rounded to F fraction bits.
   function automatic tab_type build_tab();
      tab_type tb;
      longint unsigned x, x2, term;
      longint sum, e;
      int i, k;
      for (i = 0; i < D; i++) begin
         x = (cowt_pkg::HALF_PI_Q30 * 64'(i) + 64'(D / 2)) / 64'(D);
         x2 = (x * x) >> 30;
         term = x;
         sum = longint'(x);
         for (k = 1; k <= 8; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k[0]) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         e = (sum + (longint'(1) << (29 - F))) >>> (30 - F);
         if (e > (longint'(1) << F)) begin
            e = longint'(1) << F;
         end
         tb[i] = entry_type'(e);
      end
      tb[D] = entry_type'(longint'(1) << F);
      return tb;
   endfunction

   localparam tab_type TAB = build_tab();

   entry_type mem [0:D];
   logic [AW-1:0] fill_cnt_ff;
   logic fill_done_ff;
   entry_type data_a_ff, data_b_ff;

   // Fill sweep, one entry per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_cnt_ff <= '0;
         fill_done_ff <= 1'b0;
      end else if (!fill_done_ff) begin
         if (fill_cnt_ff == AW'(D)) begin
            fill_done_ff <= 1'b1;
         end else begin
            fill_cnt_ff <= fill_cnt_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!fill_done_ff) begin
         mem[fill_cnt_ff] <= TAB[fill_cnt_ff];
      end
   end

   // Registered reads that hold while the pipeline is stalled.
   always_ff @(posedge clock) begin
      if (en) begin
         data_a_ff <= mem[addr_a];
         data_b_ff <= mem[addr_b];
      end
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;
   assign fill_done = fill_done_ff;

endmodule

### rtl/cowt_basis.sv
// Camera basis: forward, right and up axes from the sines and cosines,
// over three stages. Does not use cowt_pkg.
module cowt_basis #(
   parameter int F = 16
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [F+2:0]  sp,
   input  logic signed [F+2:0]  cp,
   input  logic signed [F+2:0]  sr,
   input  logic signed [F+2:0]  cr,
   input  logic signed [F+2:0]  sy,
   input  logic signed [F+2:0]  cy,
   output logic signed [F+2:0]  rx,
   output logic signed [F+2:0]  ry,
   output logic signed [F+2:0]  rz,
   output logic signed [F+2:0]  fx,
   output logic signed [F+2:0]  fy,
   output logic signed [F+2:0]  fz,
   output logic signed [F+2:0]  ux,
   output logic signed [F+2:0]  uy,
   output logic signed [F+2:0]  uz
);

   localparam int CW = F + 3;
   localparam int PW = 2 * CW;

   // Round half up from Q(2F) back to Q(F).
   function automatic logic signed [CW-1:0] rnd_q(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] s;
      s = (v + (PW'(1) <<< (F - 1))) >>> F;
      return CW'(s);
   endfunction

   logic signed [CW-1:0] acp;
   logic signed [CW-1:0] fx7_in, fy7_in, rx7_in, ry7_in;
   logic signed [CW-1:0] fx7_ff, fy7_ff, fz7_ff, rx7_ff, ry7_ff, rz7_ff;
   logic signed [CW-1:0] fx8_ff, fy8_ff, fz8_ff, rx8_ff, ry8_ff, rz8_ff;
   logic signed [CW-1:0] fx9_ff, fy9_ff, fz9_ff, rx9_ff, ry9_ff, rz9_ff;
   logic signed [PW-1:0] c_ryfz_ff, c_rzfy_ff, c_rzfx_ff, c_rxfz_ff, c_rxfy_ff, c_ryfx_ff;
   logic signed [CW-1:0] ux_ff, uy_ff, uz_ff;

   // First stage: forward and right components that need a product.
   always_comb begin
      acp = (cp < 0) ? -cp : cp;
      fx7_in = rnd_q(-(PW'(sy) * PW'(acp)));
      fy7_in = rnd_q(PW'(cy) * PW'(acp));
      rx7_in = rnd_q(PW'(cr) * PW'(cy));
      ry7_in = rnd_q(PW'(cr) * PW'(sy));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fx7_ff <= fx7_in;
         fy7_ff <= fy7_in;
         fz7_ff <= sp;
         rx7_ff <= rx7_in;
         ry7_ff <= ry7_in;
         rz7_ff <= -sr;
         // Second stage: partial products of right cross forward.
         c_ryfz_ff <= PW'(ry7_ff) * PW'(fz7_ff);
         c_rzfy_ff <= PW'(rz7_ff) * PW'(fy7_ff);
         c_rzfx_ff <= PW'(rz7_ff) * PW'(fx7_ff);
         c_rxfz_ff <= PW'(rx7_ff) * PW'(fz7_ff);
         c_rxfy_ff <= PW'(rx7_ff) * PW'(fy7_ff);
         c_ryfx_ff <= PW'(ry7_ff) * PW'(fx7_ff);
         fx8_ff <= fx7_ff;
         fy8_ff <= fy7_ff;
         fz8_ff <= fz7_ff;
         rx8_ff <= rx7_ff;
         ry8_ff <= ry7_ff;
         rz8_ff <= rz7_ff;
         // Third stage: differences rounded into the up axis.
         ux_ff <= rnd_q(c_ryfz_ff - c_rzfy_ff);
         uy_ff <= rnd_q(c_rzfx_ff - c_rxfz_ff);
         uz_ff <= rnd_q(c_rxfy_ff - c_ryfx_ff);
         fx9_ff <= fx8_ff;
         fy9_ff <= fy8_ff;
         fz9_ff <= fz8_ff;
         rx9_ff <= rx8_ff;
         ry9_ff <= ry8_ff;
         rz9_ff <= rz8_ff;
      end
   end

   assign rx = rx9_ff;
   assign ry = ry9_ff;
   assign rz = rz9_ff;
   assign fx = fx9_ff;
   assign fy = fy9_ff;
   assign fz = fz9_ff;
   assign ux = ux_ff;
   assign uy = uy_ff;
   assign uz = uz_ff;

endmodule

### rtl/camera_offset_to_world_unit.sv
// Camera offset to world unit: top level with the stream ports, the offset
// products, the sum and the saturation. Uses cowt_pkg, cowt_phase,
// cowt_sine_rom, cowt_basis and the assertion header.
//
// Takes one word per cycle while the output side does not stall and returns one
// word per input word, in order; the twelve register stages of the angle,
// table, basis and offset path lie between a word being taken and its result.
// After reset the three sine tables are swept full, SINE_TABLE_DEPTH + 1 entries
// at one entry per cycle, and req_tready stays low meanwhile.
`include "camera_offset_to_world_unit_assert.svh"

module camera_offset_to_world_unit #(
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int TRIG_FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // Fields from bit 0: pitch_angle 17, roll_angle 17, yaw_angle 17, cam_pos_x 32,
   // cam_pos_y 32, cam_pos_z 32, offset_right 32, offset_forward 32, offset_up 32.
   input  logic [247:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // Fields from bit 0: world_x 32, world_y 32, world_z 32.
   output logic [95:0]  rsp_tdata,
   // Fields from bit 0: saturated 1.
   output logic [0:0]   rsp_tuser
);

   localparam int D = SINE_TABLE_DEPTH;
   localparam int F = TRIG_FRAC_BITS;
   localparam int CW = F + 3;
   localparam int RW = $clog2(D);
   localparam int AW = $clog2(D + 1);
   localparam int OPW = CW + cowt_pkg::COORD_W;
   localparam int SUMW = OPW + 2;
   localparam int RSW = SUMW - F;
   localparam int WW = RSW + 1;
   localparam int STAGES = 12;
   localparam int OFF_TAP = 8;
   localparam int POS_TAP = 10;
   localparam logic signed [WW-1:0] W_MAX = WW'(cowt_pkg::COORD_MAX);
   localparam logic signed [WW-1:0] W_MIN = WW'(cowt_pkg::COORD_MIN);

   // Table magnitude with the sign of its half wave.
   function automatic logic signed [CW-1:0] signed_trig(input logic [F:0] mag,
                                                       input logic neg);
      logic signed [CW-1:0] v;
      v = signed'(CW'(mag));
      return neg ? -v : v;
   endfunction

   // Table address of the phase: mirrored in odd quadrants.
   function automatic logic [AW-1:0] tab_addr(input logic [1:0] q, input logic [RW-1:0] r);
      return q[0] ? (AW'(D) - AW'(r)) : AW'(r);
   endfunction

   // Clip one axis to 32 bits; the top bit reports a clip.
   function automatic logic [cowt_pkg::COORD_W:0] sat32(input logic signed [WW-1:0] w);
      logic [cowt_pkg::COORD_W:0] res;
      if (w > W_MAX) begin
         res = {1'b1, cowt_pkg::COORD_MAX};
      end else if (w < W_MIN) begin
         res = {1'b1, cowt_pkg::COORD_MIN};
      end else begin
         res = {1'b0, w[cowt_pkg::COORD_W-1:0]};
      end
      return res;
   endfunction

   logic en;
   logic fill_done;
   logic fill_p, fill_r, fill_y;
   logic [STAGES-1:0] valid_ff;
   cowt_pkg::coord_set_type coord_in;
   cowt_pkg::coord_set_type coord_ff [0:POS_TAP];

   logic [1:0] qp, qr, qy;
   logic [RW-1:0] ip, ir, iy;
   logic [1:0] qps5_ff, qpc5_ff, qrs5_ff, qrc5_ff, qys5_ff, qyc5_ff;
   logic [F:0] msp, mcp, msr, mcr, msy, mcy;
   logic signed [CW-1:0] sp_ff, cp_ff, sr_ff, cr_ff, sy_ff, cy_ff;
   logic signed [CW-1:0] rx, ry, rz, fx, fy, fz, ux, uy, uz;
   logic signed [OPW-1:0] p_rx_ff, p_fx_ff, p_ux_ff, p_ry_ff, p_fy_ff, p_uy_ff;
   logic signed [OPW-1:0] p_rz_ff, p_fz_ff, p_uz_ff;
   logic signed [SUMW-1:0] sum_x, sum_y, sum_z;
   logic signed [RSW-1:0] off_x_ff, off_y_ff, off_z_ff;
   logic signed [WW-1:0] w_x, w_y, w_z;
   logic [cowt_pkg::COORD_W:0] s_x, s_y, s_z;
   logic [cowt_pkg::COORD_W-1:0] world_x_ff, world_y_ff, world_z_ff;
   logic sat_ff;

   // The whole pipeline moves unless a finished word waits at the output.
   assign en = !valid_ff[STAGES-1] || rsp_tready;
   assign fill_done = fill_p && fill_r && fill_y;
   assign req_tready = en && fill_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[STAGES-2:0], req_tvalid && fill_done};
      end
   end

   // Positions and offsets follow the angles through a delay line.
   assign coord_in = req_tdata[242:51];

   always_ff @(posedge clock) begin
      if (en) begin
         coord_ff[0] <= coord_in;
         for (int j = 1; j <= POS_TAP; j++) begin
            coord_ff[j] <= coord_ff[j-1];
         end
      end
   end

   // Angle to quadrant and table index, four stages.
   cowt_phase #(.D(D)) u_phase_p (
      .clock(clock), .en(en), .angle(req_tdata[16:0]), .quad(qp), .index(ip));
   cowt_phase #(.D(D)) u_phase_r (
      .clock(clock), .en(en), .angle(req_tdata[33:17]), .quad(qr), .index(ir));
   cowt_phase #(.D(D)) u_phase_y (
      .clock(clock), .en(en), .angle(req_tdata[50:34]), .quad(qy), .index(iy));

   // Table reads: sine at the phase, cosine a quarter turn further.
   cowt_sine_rom #(.D(D), .F(F)) u_rom_p (
      .clock(clock), .reset(reset), .en(en),
      .addr_a(tab_addr(qp, ip)), .addr_b(tab_addr(qp + 2'd1, ip)),
      .data_a(msp), .data_b(mcp), .fill_done(fill_p));
   cowt_sine_rom #(.D(D), .F(F)) u_rom_r (
      .clock(clock), .reset(reset), .en(en),
      .addr_a(tab_addr(qr, ir)), .addr_b(tab_addr(qr + 2'd1, ir)),
      .data_a(msr), .data_b(mcr), .fill_done(fill_r));
   cowt_sine_rom #(.D(D), .F(F)) u_rom_y (
      .clock(clock), .reset(reset), .en(en),
      .addr_a(tab_addr(qy, iy)), .addr_b(tab_addr(qy + 2'd1, iy)),
      .data_a(msy), .data_b(mcy), .fill_done(fill_y));

   // Quadrants ride along with the table read, then sign the values.
   always_ff @(posedge clock) begin
      if (en) begin
         qps5_ff <= qp;
         qpc5_ff <= qp + 2'd1;
         qrs5_ff <= qr;
         qrc5_ff <= qr + 2'd1;
         qys5_ff <= qy;
         qyc5_ff <= qy + 2'd1;
         sp_ff <= signed_trig(msp, qps5_ff[1]);
         cp_ff <= signed_trig(mcp, qpc5_ff[1]);
         sr_ff <= signed_trig(msr, qrs5_ff[1]);
         cr_ff <= signed_trig(mcr, qrc5_ff[1]);
         sy_ff <= signed_trig(msy, qys5_ff[1]);
         cy_ff <= signed_trig(mcy, qyc5_ff[1]);
      end
   end

   cowt_basis #(.F(F)) u_basis (
      .clock(clock), .en(en),
      .sp(sp_ff), .cp(cp_ff), .sr(sr_ff), .cr(cr_ff), .sy(sy_ff), .cy(cy_ff),
      .rx(rx), .ry(ry), .rz(rz), .fx(fx), .fy(fy), .fz(fz),
      .ux(ux), .uy(uy), .uz(uz));

   // Offset products, exact sum rounded to Q16.16, then position and clip.
   always_comb begin
      sum_x = SUMW'(p_rx_ff) + SUMW'(p_fx_ff) + SUMW'(p_ux_ff) + (SUMW'(1) <<< (F - 1));
      sum_y = SUMW'(p_ry_ff) + SUMW'(p_fy_ff) + SUMW'(p_uy_ff) + (SUMW'(1) <<< (F - 1));
      sum_z = SUMW'(p_rz_ff) + SUMW'(p_fz_ff) + SUMW'(p_uz_ff) + (SUMW'(1) <<< (F - 1));
      w_x = WW'(coord_ff[POS_TAP].pos_x) + WW'(off_x_ff);
      w_y = WW'(coord_ff[POS_TAP].pos_y) + WW'(off_y_ff);
      w_z = WW'(coord_ff[POS_TAP].pos_z) + WW'(off_z_ff);
      s_x = sat32(w_x);
      s_y = sat32(w_y);
      s_z = sat32(w_z);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_rx_ff <= OPW'(rx) * OPW'(coord_ff[OFF_TAP].off_r);
         p_fx_ff <= OPW'(fx) * OPW'(coord_ff[OFF_TAP].off_f);
         p_ux_ff <= OPW'(ux) * OPW'(coord_ff[OFF_TAP].off_u);
         p_ry_ff <= OPW'(ry) * OPW'(coord_ff[OFF_TAP].off_r);
         p_fy_ff <= OPW'(fy) * OPW'(coord_ff[OFF_TAP].off_f);
         p_uy_ff <= OPW'(uy) * OPW'(coord_ff[OFF_TAP].off_u);
         p_rz_ff <= OPW'(rz) * OPW'(coord_ff[OFF_TAP].off_r);
         p_fz_ff <= OPW'(fz) * OPW'(coord_ff[OFF_TAP].off_f);
         p_uz_ff <= OPW'(uz) * OPW'(coord_ff[OFF_TAP].off_u);
         off_x_ff <= RSW'(sum_x >>> F);
         off_y_ff <= RSW'(sum_y >>> F);
         off_z_ff <= RSW'(sum_z >>> F);
         world_x_ff <= s_x[cowt_pkg::COORD_W-1:0];
         world_y_ff <= s_y[cowt_pkg::COORD_W-1:0];
         world_z_ff <= s_z[cowt_pkg::COORD_W-1:0];
         sat_ff <= s_x[cowt_pkg::COORD_W] | s_y[cowt_pkg::COORD_W] | s_z[cowt_pkg::COORD_W];
      end
   end

   assign rsp_tvalid = valid_ff[STAGES-1];
   assign rsp_tdata = {world_z_ff, world_y_ff, world_x_ff};
   assign rsp_tuser = sat_ff;

   // No word may be in flight while the tables are still being filled.
   `COWT_ASSERT_IMP(a_idle_during_fill, !fill_done, valid_ff == '0, "word in flight during fill")
   // A stalled output freezes every stage.
   `COWT_ASSERT_NXT(a_stall_freezes, rsp_tvalid && !rsp_tready, $stable(valid_ff), "pipeline moved during stall")
   // A clipped word has at least one axis on a rail.
   `COWT_ASSERT_IMP(a_sat_on_rail, rsp_tvalid && sat_ff, (world_x_ff == cowt_pkg::COORD_MAX) || (world_x_ff == cowt_pkg::COORD_MIN) || (world_y_ff == cowt_pkg::COORD_MAX) || (world_y_ff == cowt_pkg::COORD_MIN) || (world_z_ff == cowt_pkg::COORD_MAX) || (world_z_ff == cowt_pkg::COORD_MIN), "saturated without a clipped axis")

endmodule
